### rtl/nfc_block_framer_crc_a_macros.svh
// Assertion macros shared by the checkers of the NFC block framer.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef NFC_BLOCK_FRAMER_CRC_A_MACROS_SVH
`define NFC_BLOCK_FRAMER_CRC_A_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define NFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfc framer check failed");

// Next-cycle implication, disabled while reset is high
`define NFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfc framer check failed");

// Next-cycle implication that stays live during reset
`define NFC_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("nfc framer check failed");

`endif

### rtl/nfc_bf_pkg.sv
// Types, constants and the CRC-A byte update for the NFC block framer.
// No dependencies; used by every module of the block.
package nfc_bf_pkg;

   localparam logic [15:0] CRC_A_INIT   = 16'h6363;
   localparam logic [15:0] CRC_LOW_MASK = 16'h00FF;
   localparam logic [7:0]  IBLOCK_HDR   = 8'h02;
   localparam logic [7:0]  DESELECT_HDR = 8'hC2;

   typedef enum logic [1:0] {
      REQ_PAYLOAD  = 2'd0,
      REQ_TX_FAIL  = 2'd1,
      REQ_DESELECT = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_kind_type;

   // One CRC-A step over one byte
   function automatic logic [15:0] crc_a_update(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  t;
      logic [15:0] w;
      logic [15:0] m;
      m = crc & CRC_LOW_MASK;
      t = b ^ m[7:0];
      t = t ^ {t[3:0], 4'b0000};
      w = {8'h00, t};
      return {8'h00, crc[15:8]} ^ {w[7:0], 8'h00} ^ {w[12:0], 3'b000} ^ {4'h0, w[15:4]};
   endfunction

   localparam logic [15:0] DESELECT_CRC = crc_a_update(CRC_A_INIT, DESELECT_HDR);

   // Up to four words produced by one request
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            has_crc;
   } burst_type;

   typedef struct packed {
      logic      valid;
      burst_type burst;
   } load_type;

endpackage

### rtl/nfc_bf_frame.sv
// Framing state (block number, running CRC, open frame) and burst builder.
// Depends on nfc_bf_pkg.
module nfc_bf_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            req_type,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output nfc_bf_pkg::load_type  load
);

   logic        bn_ff, bn_in;
   logic [15:0] crc_ff, crc_in;
   logic        open_ff, open_in;

   logic [7:0]  hdr;
   logic [15:0] crc_hdr, crc_base, crc_dat;
   nfc_bf_pkg::req_kind_type kind;

   assign kind     = nfc_bf_pkg::req_kind_type'(req_type);
   assign hdr      = nfc_bf_pkg::IBLOCK_HDR | {7'b0, bn_ff};
   assign crc_hdr  = nfc_bf_pkg::crc_a_update(nfc_bf_pkg::CRC_A_INIT, hdr);
   assign crc_base = open_ff ? crc_ff : crc_hdr;
   assign crc_dat  = nfc_bf_pkg::crc_a_update(crc_base, data_byte);

   // Build the burst and the next framing state
   always_comb begin
      bn_in   = bn_ff;
      crc_in  = crc_ff;
      open_in = open_ff;
      load    = '0;
      if (accept) begin
         unique case (kind)
            nfc_bf_pkg::REQ_PAYLOAD: begin
               load.valid         = 1'b1;
               load.burst.has_crc = last_byte;
               if (open_ff) begin
                  load.burst.bytes[0] = data_byte;
                  load.burst.bytes[1] = crc_dat[7:0];
                  load.burst.bytes[2] = crc_dat[15:8];
                  load.burst.bytes[3] = 8'h00;
                  load.burst.last_idx = last_byte ? 2'd2 : 2'd0;
               end else begin
                  load.burst.bytes[0] = hdr;
                  load.burst.bytes[1] = data_byte;
                  load.burst.bytes[2] = crc_dat[7:0];
                  load.burst.bytes[3] = crc_dat[15:8];
                  load.burst.last_idx = last_byte ? 2'd3 : 2'd1;
               end
               open_in = ~last_byte;
               crc_in  = last_byte ? nfc_bf_pkg::CRC_A_INIT : crc_dat;
               bn_in   = bn_ff ^ last_byte;
            end
            nfc_bf_pkg::REQ_TX_FAIL: begin
               bn_in   = 1'b0;
               crc_in  = nfc_bf_pkg::CRC_A_INIT;
               open_in = 1'b0;
            end
            nfc_bf_pkg::REQ_DESELECT: begin
               load.valid          = 1'b1;
               load.burst.bytes[0] = nfc_bf_pkg::DESELECT_HDR;
               load.burst.bytes[1] = nfc_bf_pkg::DESELECT_CRC[7:0];
               load.burst.bytes[2] = nfc_bf_pkg::DESELECT_CRC[15:8];
               load.burst.bytes[3] = 8'h00;
               load.burst.last_idx = 2'd2;
               load.burst.has_crc  = 1'b1;
               crc_in  = nfc_bf_pkg::CRC_A_INIT;
               open_in = 1'b0;
            end
            nfc_bf_pkg::REQ_UNUSED: begin
               // drop: state unchanged
            end
            default: begin
            end
         endcase
      end
   end

   // Hold framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         bn_ff   <= 1'b0;
         crc_ff  <= nfc_bf_pkg::CRC_A_INIT;
         open_ff <= 1'b0;
      end else begin
         bn_ff   <= bn_in;
         crc_ff  <= crc_in;
         open_ff <= open_in;
      end
   end

endmodule

### rtl/nfc_bf_ser.sv
// Result register: holds one burst and sends its words one per cycle while rsp_tready is high.
// Depends on nfc_bf_pkg.
module nfc_bf_ser (
   input  logic                  clock,
   input  logic                  reset,
   input  nfc_bf_pkg::load_type  load,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic [0:0]            rsp_tuser
);

   nfc_bf_pkg::burst_type burst_ff, burst_in;
   logic                  valid_ff, valid_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  at_end;

   assign at_end = (idx_ff == burst_ff.last_idx);
   assign free   = ~valid_ff | (rsp_tready & at_end);

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = burst_ff.bytes[idx_ff];
   assign rsp_tlast    = at_end & burst_ff.has_crc;
   assign rsp_tuser[0] = at_end;

   // Load a new burst or advance through the current one
   always_comb begin
      burst_in = burst_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load.valid) begin
         burst_in = load.burst;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp_tready) begin
         if (at_end) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

endmodule

### rtl/nfc_block_framer_crc_a.sv
// Channel | tdata              | tuser        | tlast
// req     | data_byte[7:0]     | req_type[1:0]| last_byte
// rsp     | out_byte[7:0]      | run_last     | frame_end
//
// A request is taken while req_tready is high; its words (none to four) leave one per cycle while rsp_tready is high.
// The next request is taken in the cycle the last word of the current burst goes,
// so throughput is set by the single burst register in nfc_bf_ser.
// Reset (synchronous, high) clears block number, CRC (0x6363) and open frame.
// A stall on rsp holds the current word; req_tready stays low until the last
// word of the burst is taken.
// Top level of the NFC I-block framer; uses nfc_bf_pkg, nfc_bf_frame, nfc_bf_ser.
module nfc_block_framer_crc_a (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] req_type
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [0:0] rsp_tuser,   // [0] run_last
   output logic       rsp_tlast
);

   nfc_bf_pkg::load_type load;
   logic                 free;
   logic                 accept;

   assign req_tready = free;
   assign accept     = req_tvalid & free;

   nfc_bf_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_tuser),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .load      (load)
   );

   nfc_bf_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/nfc_bf_check.sv
// Port-level checker for the NFC block framer, bound to the top level.
// Depends on nfc_block_framer_crc_a_macros.svh and nfc_bf_pkg.
`include "nfc_block_framer_crc_a_macros.svh"

module nfc_bf_check (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser,
   input logic       rsp_tlast
);

   logic rsp_stall;
   logic fail_taken;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign fail_taken = req_tvalid && req_tready && (req_tuser == nfc_bf_pkg::REQ_TX_FAIL);

   // Stalled word holds
   `NFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // A frame closes only on the last word of a burst
   `NFC_ASSERT_NOW(a_end_is_last, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[0])
   // A transmit failure sends nothing
   `NFC_ASSERT_NEXT(a_fail_quiet, clock, reset, fail_taken, !rsp_tvalid)
   // Output is empty right after reset
   `NFC_ASSERT_NEXT_ANY(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind nfc_block_framer_crc_a nfc_bf_check u_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
